// File: rtl/dapid_pkg.sv
// Shared types and constants for the dual-axis PID controller.
// Used by the channel interfaces, the register file, the sequencer, the datapath and the top level.
package dapid_pkg;

    localparam int NUM_JOINTS    = 2;
    localparam int OUT_JOINTS    = 2;
    localparam int ACTIVE_JOINTS = (NUM_JOINTS < OUT_JOINTS) ? NUM_JOINTS : OUT_JOINTS;
    localparam int JIDX_W        = (ACTIVE_JOINTS > 1) ? $clog2(ACTIVE_JOINTS) : 1;

    localparam int ANGLE_W = 32;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int QUO_W   = 47;
    localparam int INTEG_W = 48;
    localparam int SUM_W   = 50;
    localparam int PROD_W  = 64;

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] PROP_GAIN_RST  = 32'd131072000;
    localparam logic [15:0] DERIV_TIME_RST = 16'd3277;
    localparam logic [15:0] INTEG_RATE_RST = 16'd218;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_DERIV_TIME = 2'd1,
        REG_INTEG_RATE = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ERR,
        OP_DIFF,
        OP_MAG,
        OP_DIV,
        OP_DT_LO,
        OP_DT_HI,
        OP_DT_ADD,
        OP_D_CAP,
        OP_I_CAP,
        OP_I_MAG,
        OP_IR_LO,
        OP_IR_HI,
        OP_IR_ADD,
        OP_IT_CAP,
        OP_SUM,
        OP_ABS,
        OP_PG_HI,
        OP_PG_LO,
        OP_PG_ADD,
        OP_TQ_CAP
    } op_t;

    typedef struct packed {
        logic [31:0] prop_gain;
        logic [15:0] deriv_time;
        logic [15:0] integ_rate;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [JIDX_W-1:0] joint;
        logic              take;
        logic              publish;
    } dp_cmd_t;

    typedef struct packed {
        logic elapsed_zero;
    } dp_status_t;

endpackage

// File: rtl/dapid_if.sv
// Channel interfaces of the dual-axis PID controller: sample, result and register write.
// Depends on dapid_pkg for field widths.
interface dapid_sample_if import dapid_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] meas_angle_a;
    logic signed [ANGLE_W-1:0] meas_angle_b;
    logic signed [ANGLE_W-1:0] target_angle_a;
    logic signed [ANGLE_W-1:0] target_angle_b;
    logic        [31:0]        elapsed;

    modport source (
        output valid, meas_angle_a, meas_angle_b, target_angle_a, target_angle_b, elapsed,
        input  ready
    );
    modport sink (
        input  valid, meas_angle_a, meas_angle_b, target_angle_a, target_angle_b, elapsed,
        output ready
    );
endinterface

interface dapid_result_if import dapid_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] torque_a;
    logic signed [ANGLE_W-1:0] torque_b;
    logic        [1:0]         sat_flags;

    modport source (
        output valid, torque_a, torque_b, sat_flags,
        input  ready
    );
    modport sink (
        input  valid, torque_a, torque_b, sat_flags,
        output ready
    );
endinterface

interface dapid_cfg_if import dapid_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/dapid_regs.sv
// Gain register file of the dual-axis PID controller.
// Depends on dapid_pkg and dapid_cfg_if.
module dapid_regs import dapid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dapid_cfg_if.sink   cfg,
    output cfg_t        gains
);

    logic [31:0] prop_gain_reg;
    logic [15:0] deriv_time_reg;
    logic [15:0] integ_rate_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_time_reg <= DERIV_TIME_RST;
            integ_rate_reg <= INTEG_RATE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg.data[31:0];
                REG_DERIV_TIME: deriv_time_reg <= cfg.data[15:0];
                REG_INTEG_RATE: integ_rate_reg <= cfg.data[15:0];
                default:        ;
            endcase
        end
    end

    assign gains.prop_gain  = prop_gain_reg;
    assign gains.deriv_time = deriv_time_reg;
    assign gains.integ_rate = integ_rate_reg;

endmodule

// File: rtl/dapid_ctrl.sv
// Sequencer of the dual-axis PID controller: steps each joint through error, division,
// multiply passes and torque, and runs the sample and result handshakes. Depends on dapid_pkg.
module dapid_ctrl import dapid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_MAG,
        ST_DIV,
        ST_DT_LO,
        ST_DT_HI,
        ST_DT_ADD,
        ST_D_CAP,
        ST_I_CAP,
        ST_I_MAG,
        ST_IR_LO,
        ST_IR_HI,
        ST_IR_ADD,
        ST_IT_CAP,
        ST_SUM,
        ST_ABS,
        ST_PG_HI,
        ST_PG_LO,
        ST_PG_ADD,
        ST_TQ_CAP,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [JIDX_W-1:0] joint_reg, joint_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    op_t               op_reg, op_next;
    logic              out_valid_reg, out_valid_next;
    logic              take;
    logic              publish;

    function automatic op_t op_of(input state_t st);
        op_t op;
        case (st)
            ST_ERR:    op = OP_ERR;
            ST_DIFF:   op = OP_DIFF;
            ST_MAG:    op = OP_MAG;
            ST_DIV:    op = OP_DIV;
            ST_DT_LO:  op = OP_DT_LO;
            ST_DT_HI:  op = OP_DT_HI;
            ST_DT_ADD: op = OP_DT_ADD;
            ST_D_CAP:  op = OP_D_CAP;
            ST_I_CAP:  op = OP_I_CAP;
            ST_I_MAG:  op = OP_I_MAG;
            ST_IR_LO:  op = OP_IR_LO;
            ST_IR_HI:  op = OP_IR_HI;
            ST_IR_ADD: op = OP_IR_ADD;
            ST_IT_CAP: op = OP_IT_CAP;
            ST_SUM:    op = OP_SUM;
            ST_ABS:    op = OP_ABS;
            ST_PG_HI:  op = OP_PG_HI;
            ST_PG_LO:  op = OP_PG_LO;
            ST_PG_ADD: op = OP_PG_ADD;
            ST_TQ_CAP: op = OP_TQ_CAP;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign publish  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        joint_next = joint_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && !status.elapsed_zero)
                begin
                    state_next = ST_ERR;
                    joint_next = '0;
                end
            end
            ST_ERR:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MAG;
            ST_MAG:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DT_LO;
                end
            end
            ST_DT_LO:  state_next = ST_DT_HI;
            ST_DT_HI:  state_next = ST_DT_ADD;
            ST_DT_ADD: state_next = ST_D_CAP;
            ST_D_CAP:  state_next = ST_I_CAP;
            ST_I_CAP:  state_next = ST_I_MAG;
            ST_I_MAG:  state_next = ST_IR_LO;
            ST_IR_LO:  state_next = ST_IR_HI;
            ST_IR_HI:  state_next = ST_IR_ADD;
            ST_IR_ADD: state_next = ST_IT_CAP;
            ST_IT_CAP: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ABS;
            ST_ABS:    state_next = ST_PG_HI;
            ST_PG_HI:  state_next = ST_PG_LO;
            ST_PG_LO:  state_next = ST_PG_ADD;
            ST_PG_ADD: state_next = ST_TQ_CAP;
            ST_TQ_CAP:
            begin
                if (joint_reg == JIDX_W'(ACTIVE_JOINTS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ERR;
                    joint_next = joint_reg + JIDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase

        op_next = op_of(state_next);

        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            joint_reg     <= '0;
            cnt_reg       <= '0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            joint_reg     <= joint_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd.op      = op_reg;
    assign cmd.joint   = joint_reg;
    assign cmd.take    = take;
    assign cmd.publish = publish;

endmodule

// File: rtl/dapid_dp.sv
// Datapath of the dual-axis PID controller: sample registers, joint state, restoring
// divider, shared 32x32 multiplier with accumulator, and result word. Depends on dapid_pkg.
module dapid_dp import dapid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      gains,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic signed [ANGLE_W-1:0] meas_angle_a,
    input  logic signed [ANGLE_W-1:0] meas_angle_b,
    input  logic signed [ANGLE_W-1:0] target_angle_a,
    input  logic signed [ANGLE_W-1:0] target_angle_b,
    input  logic        [31:0]        elapsed,
    output logic signed [ANGLE_W-1:0] torque_a,
    output logic signed [ANGLE_W-1:0] torque_b,
    output logic        [1:0]         sat_flags
);

    logic [ANGLE_W-1:0] meas_reg [OUT_JOINTS];
    logic [ANGLE_W-1:0] targ_reg [OUT_JOINTS];
    logic [31:0]        h_reg;

    logic [ERR_W-1:0]   prev_err_reg [ACTIVE_JOINTS];
    logic [INTEG_W-1:0] integ_reg    [ACTIVE_JOINTS];

    logic [ERR_W-1:0]   e_reg;
    logic               e_neg_reg;
    logic [31:0]        emag_reg;
    logic [DIFF_W-1:0]  de_reg;
    logic               de_neg_reg;
    logic [DIFF_W-1:0]  demag_reg;
    logic [31:0]        rem_reg;
    logic [QUO_W-1:0]   dq_reg;
    logic               dsat_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [INTEG_W-1:0] dterm_reg;
    logic [INTEG_W-1:0] iterm_reg;
    logic [INTEG_W-1:0] imag_reg;
    logic               i_neg_reg;
    logic [SUM_W-1:0]   s_reg;
    logic [SUM_W-2:0]   smag_reg;
    logic               s_neg_reg;
    logic               pg_ovf_reg;
    logic               jsat_reg;
    logic [ANGLE_W-1:0] tq_reg [OUT_JOINTS];
    logic [OUT_JOINTS-1:0] flag_reg;

    logic [ANGLE_W-1:0] res_torque_a_reg;
    logic [ANGLE_W-1:0] res_torque_b_reg;
    logic [1:0]         res_flags_reg;

    logic [ERR_W-1:0]   e_next;
    logic [DIFF_W-1:0]  de_next;
    logic [DIFF_W-1:0]  demag_next;
    logic [ERR_W-1:0]   emag_full;
    logic [32:0]        div_trial;
    logic               div_ge;
    logic [32:0]        div_diff;
    logic               dsat_next;
    logic [QUO_W-1:0]   qval;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [INTEG_W-1:0] dterm_next;
    logic [INTEG_W-1:0] iterm_next;
    logic [39:0]        inc_mag;
    logic [INTEG_W:0]   ni_sum;
    logic               ni_ovf;
    logic [INTEG_W-1:0] ni_clamped;
    logic [INTEG_W-1:0] integ_cur;
    logic [SUM_W-1:0]   s_next;
    logic [SUM_W-1:0]   smag_full;
    logic [PROD_W-1:0]  tq_limit;
    logic               tq_sat;
    logic [ANGLE_W-1:0] tq_mag;
    logic [ANGLE_W-1:0] tq_next;

    assign status.elapsed_zero = (elapsed == 32'd0);

    always_comb
    begin
        e_next = {targ_reg[cmd.joint][ANGLE_W-1], targ_reg[cmd.joint]}
               - {meas_reg[cmd.joint][ANGLE_W-1], meas_reg[cmd.joint]};
        de_next = {e_reg[ERR_W-1], e_reg}
                - {prev_err_reg[cmd.joint][ERR_W-1], prev_err_reg[cmd.joint]};
        demag_next = de_reg[DIFF_W-1] ? (~de_reg + DIFF_W'(1)) : de_reg;
        emag_full  = e_reg[ERR_W-1] ? (~e_reg + ERR_W'(1)) : e_reg;

        div_trial = {rem_reg, dq_reg[QUO_W-1]};
        div_diff  = div_trial - {1'b0, h_reg};
        div_ge    = (div_trial >= {1'b0, h_reg});
        dsat_next = ({21'd0, demag_reg} >= {h_reg, 23'd0});
        qval      = dsat_reg ? {QUO_W{1'b1}} : dq_reg;

        case (cmd.op)
            OP_DT_LO:
            begin
                mul_a = qval[31:0];
                mul_b = {16'd0, gains.deriv_time};
            end
            OP_DT_HI:
            begin
                mul_a = {17'd0, qval[QUO_W-1:32]};
                mul_b = {16'd0, gains.deriv_time};
            end
            OP_DT_ADD:
            begin
                mul_a = h_reg;
                mul_b = emag_reg;
            end
            OP_IR_LO:
            begin
                mul_a = imag_reg[31:0];
                mul_b = {16'd0, gains.integ_rate};
            end
            OP_IR_HI:
            begin
                mul_a = {16'd0, imag_reg[INTEG_W-1:32]};
                mul_b = {16'd0, gains.integ_rate};
            end
            OP_PG_HI:
            begin
                mul_a = gains.prop_gain;
                mul_b = {15'd0, smag_reg[SUM_W-2:32]};
            end
            OP_PG_LO:
            begin
                mul_a = gains.prop_gain;
                mul_b = smag_reg[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        dterm_next = de_neg_reg ? (~{1'b0, acc_reg[62:16]} + INTEG_W'(1))
                                : {1'b0, acc_reg[62:16]};
        iterm_next = i_neg_reg ? (~{1'b0, acc_reg[62:16]} + INTEG_W'(1))
                               : {1'b0, acc_reg[62:16]};

        inc_mag = acc_reg[63:24];
        if (e_neg_reg)
        begin
            ni_sum = {integ_reg[cmd.joint][INTEG_W-1], integ_reg[cmd.joint]}
                   - {9'd0, inc_mag};
        end
        else
        begin
            ni_sum = {integ_reg[cmd.joint][INTEG_W-1], integ_reg[cmd.joint]}
                   + {9'd0, inc_mag};
        end
        ni_ovf = ni_sum[INTEG_W] ^ ni_sum[INTEG_W-1];
        if (!ni_ovf)
        begin
            ni_clamped = ni_sum[INTEG_W-1:0];
        end
        else if (ni_sum[INTEG_W])
        begin
            ni_clamped = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            ni_clamped = {1'b0, {(INTEG_W-1){1'b1}}};
        end

        integ_cur = integ_reg[cmd.joint];

        s_next = {{(SUM_W-ERR_W){e_reg[ERR_W-1]}}, e_reg}
               + {{(SUM_W-INTEG_W){dterm_reg[INTEG_W-1]}}, dterm_reg}
               + {{(SUM_W-INTEG_W){iterm_reg[INTEG_W-1]}}, iterm_reg};
        smag_full = s_reg[SUM_W-1] ? (~s_reg + SUM_W'(1)) : s_reg;

        tq_limit = s_neg_reg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        tq_sat   = pg_ovf_reg || (acc_reg > tq_limit);
        tq_mag   = tq_sat ? tq_limit[31:0] : acc_reg[31:0];
        tq_next  = s_neg_reg ? (~tq_mag + 32'd1) : tq_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ACTIVE_JOINTS; k++)
            begin
                prev_err_reg[k] <= '0;
                integ_reg[k]    <= '0;
            end
        end
        else if (cmd.op == OP_I_CAP)
        begin
            prev_err_reg[cmd.joint] <= e_reg;
            integ_reg[cmd.joint]    <= ni_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.take)
        begin
            meas_reg[0] <= meas_angle_a;
            meas_reg[1] <= meas_angle_b;
            targ_reg[0] <= target_angle_a;
            targ_reg[1] <= target_angle_b;
            h_reg       <= elapsed;
        end

        case (cmd.op)
            OP_ERR:
            begin
                e_reg    <= e_next;
                jsat_reg <= 1'b0;
            end
            OP_DIFF:
            begin
                de_reg <= de_next;
            end
            OP_MAG:
            begin
                demag_reg  <= demag_next;
                de_neg_reg <= de_reg[DIFF_W-1];
                emag_reg   <= emag_full[31:0];
                e_neg_reg  <= e_reg[ERR_W-1];
                rem_reg    <= {21'd0, demag_next[DIFF_W-1:23]};
                dq_reg     <= {demag_next[22:0], 24'd0};
            end
            OP_DIV:
            begin
                rem_reg  <= div_ge ? div_diff[31:0] : div_trial[31:0];
                dq_reg   <= {dq_reg[QUO_W-2:0], div_ge};
                dsat_reg <= dsat_next;
            end
            OP_DT_HI:
            begin
                acc_reg <= prod_reg;
            end
            OP_DT_ADD:
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
            OP_D_CAP:
            begin
                dterm_reg <= dterm_next;
                jsat_reg  <= jsat_reg | dsat_reg;
                acc_reg   <= prod_reg;
            end
            OP_I_CAP:
            begin
                jsat_reg <= jsat_reg | ni_ovf;
            end
            OP_I_MAG:
            begin
                imag_reg  <= integ_cur[INTEG_W-1] ? (~integ_cur + INTEG_W'(1)) : integ_cur;
                i_neg_reg <= integ_cur[INTEG_W-1];
            end
            OP_IR_HI:
            begin
                acc_reg <= prod_reg;
            end
            OP_IR_ADD:
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
            OP_IT_CAP:
            begin
                iterm_reg <= iterm_next;
            end
            OP_SUM:
            begin
                s_reg <= s_next;
            end
            OP_ABS:
            begin
                smag_reg  <= smag_full[SUM_W-2:0];
                s_neg_reg <= s_reg[SUM_W-1];
            end
            OP_PG_LO:
            begin
                pg_ovf_reg <= |prod_reg[PROD_W-1:31];
                acc_reg    <= {prod_reg[PROD_W-17:0], 16'd0};
            end
            OP_PG_ADD:
            begin
                acc_reg <= acc_reg + {16'd0, prod_reg[PROD_W-1:16]};
            end
            OP_TQ_CAP:
            begin
                tq_reg[cmd.joint]   <= tq_next;
                flag_reg[cmd.joint] <= jsat_reg | tq_sat;
            end
            default: ;
        endcase

        if (cmd.publish)
        begin
            res_torque_a_reg <= tq_reg[0];
            res_torque_b_reg <= (ACTIVE_JOINTS > 1) ? tq_reg[1] : '0;
            res_flags_reg    <= {(ACTIVE_JOINTS > 1) && flag_reg[1], flag_reg[0]};
        end
    end

    assign torque_a  = res_torque_a_reg;
    assign torque_b  = res_torque_b_reg;
    assign sat_flags = res_flags_reg;

endmodule

// File: rtl/dual_axis_pid_controller.sv
// Dual-axis PID controller: takes a sample word with two measured and two target joint angles
// and the elapsed time, and returns one result word with both drive torques and the saturation
// flags. Each joint goes through the one-bit-per-cycle restoring divider that forms the
// derivative, then seven passes through the one shared 32x32 multiplier and the sum and clamp
// steps. A sample with zero elapsed time is taken and dropped: no result, no change of joint
// state. The next sample is taken while the last result word still waits in the output register.
// Gains may be written at any time the block holds no sample in work.
// Depends on dapid_pkg, the channel interfaces, dapid_regs, dapid_ctrl and dapid_dp.
module dual_axis_pid_controller import dapid_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    dapid_cfg_if.sink       cfg,
    dapid_sample_if.sink    sample,
    dapid_result_if.source  result
);

    cfg_t       gains;
    dp_cmd_t    cmd;
    dp_status_t status;

    dapid_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .gains (gains)
    );

    dapid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dapid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .gains          (gains),
        .cmd            (cmd),
        .status         (status),
        .meas_angle_a   (sample.meas_angle_a),
        .meas_angle_b   (sample.meas_angle_b),
        .target_angle_a (sample.target_angle_a),
        .target_angle_b (sample.target_angle_b),
        .elapsed        (sample.elapsed),
        .torque_a       (result.torque_a),
        .torque_b       (result.torque_b),
        .sat_flags      (result.sat_flags)
    );

endmodule

// File: verif/dual_axis_pid_controller_tb.sv
// Self-checking testbench for dual_axis_pid_controller: random and directed sample words,
// gain changes between phases, and torque/flag checks against a fixed-point PID predictor.
// Depends on dapid_pkg, the channel interfaces in dapid_if.sv and the controller RTL.
module dual_axis_pid_controller_tb import dapid_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 3000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [31:0] ANGLE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ANGLE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] meas_angle_a;
        logic signed [ANGLE_W-1:0] meas_angle_b;
        logic signed [ANGLE_W-1:0] target_angle_a;
        logic signed [ANGLE_W-1:0] target_angle_b;
        logic        [31:0]        elapsed;
    } sample_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] torque_a;
        logic signed [ANGLE_W-1:0] torque_b;
        logic        [1:0]         sat_flags;
    } torque_word_t;

    class torque_checker;
        bit [31:0]    prop_gain;
        bit [15:0]    deriv_time;
        bit [15:0]    integ_rate;
        longint       prev_err [ACTIVE_JOINTS];
        longint       integral [ACTIVE_JOINTS];
        torque_word_t pending_torques [$];
        int unsigned  errors;
        int unsigned  samples;
        int unsigned  idle_samples;
        int unsigned  results;
        int unsigned  sat_results;

        function new();
            prop_gain    = PROP_GAIN_RST;
            deriv_time   = DERIV_TIME_RST;
            integ_rate   = INTEG_RATE_RST;
            foreach (prev_err[j])
            begin
                prev_err[j] = 0;
                integral[j] = 0;
            end
            errors       = 0;
            samples      = 0;
            idle_samples = 0;
            results      = 0;
            sat_results  = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_PROP_GAIN:  prop_gain  = data;
                REG_DERIV_TIME: deriv_time = data[15:0];
                REG_INTEG_RATE: integ_rate = data[15:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] magnitude(longint v);
            if (v < 0)
                return -v;
            return v;
        endfunction

        function longint with_sign(bit [63:0] mag, bit neg);
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function bit joint_torque(int j, longint meas, longint targ, bit [63:0] step,
                                  output longint torque);
            longint    e;
            longint    de;
            longint    dterm;
            longint    inc;
            longint    ni;
            longint    iterm;
            longint    s;
            bit [63:0] q;
            bit [63:0] smag;
            bit [63:0] hi;
            bit [63:0] lim;
            bit [63:0] m;
            bit        sat;
            sat = 1'b0;
            e   = targ - meas;
            de  = e - prev_err[j];
            q   = (magnitude(de) << 24) / step;
            if (q > 64'h0000_7FFF_FFFF_FFFF)
            begin
                q   = 64'h0000_7FFF_FFFF_FFFF;
                sat = 1'b1;
            end
            dterm = with_sign((q * 64'(deriv_time)) >> 16, de < 0);
            inc   = with_sign((step * magnitude(e)) >> 24, e < 0);
            ni    = integral[j] + inc;
            if (ni > 64'sh0000_7FFF_FFFF_FFFF)
            begin
                ni  = 64'sh0000_7FFF_FFFF_FFFF;
                sat = 1'b1;
            end
            if (ni < -64'sh0000_8000_0000_0000)
            begin
                ni  = -64'sh0000_8000_0000_0000;
                sat = 1'b1;
            end
            integral[j] = ni;
            prev_err[j] = e;
            iterm = with_sign((magnitude(ni) * 64'(integ_rate)) >> 16, ni < 0);
            s     = e + dterm + iterm;
            smag  = magnitude(s);
            hi    = 64'(prop_gain) * (smag >> 32);
            lim   = (s < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (hi >= 64'h8000_0000)
                m = lim + 1;
            else
                m = (hi << 16) + ((64'(prop_gain) * 64'(smag[31:0])) >> 16);
            if (m > lim)
            begin
                m   = lim;
                sat = 1'b1;
            end
            torque = with_sign(m, s < 0);
            return sat;
        endfunction

        function void note_sample(sample_word_t w);
            longint       meas [2];
            longint       targ [2];
            longint       tq [2];
            torque_word_t want;
            samples++;
            if (w.elapsed == 0)
            begin
                idle_samples++;
                return;
            end
            meas[0] = w.meas_angle_a;
            meas[1] = w.meas_angle_b;
            targ[0] = w.target_angle_a;
            targ[1] = w.target_angle_b;
            tq[0]   = 0;
            tq[1]   = 0;
            want    = '0;
            for (int j = 0; j < ACTIVE_JOINTS; j++)
            begin
                if (joint_torque(j, meas[j], targ[j], 64'(w.elapsed), tq[j]))
                    want.sat_flags[j] = 1'b1;
            end
            want.torque_a = tq[0][31:0];
            want.torque_b = tq[1][31:0];
            pending_torques = {pending_torques, want};
        endfunction

        function void check_result(torque_word_t got);
            torque_word_t want;
            results++;
            if (got.sat_flags != 0)
                sat_results++;
            if (pending_torques.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR at %0t: unexpected result torque_a=%0d torque_b=%0d flags=%b",
                             $time, got.torque_a, got.torque_b, got.sat_flags);
                return;
            end
            want = pending_torques.pop_front();
            if (got.torque_a !== want.torque_a || got.torque_b !== want.torque_b ||
                got.sat_flags !== want.sat_flags)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR at %0t: expected a=%0d b=%0d flags=%b, got a=%0d b=%0d flags=%b",
                             $time, want.torque_a, want.torque_b, want.sat_flags,
                             got.torque_a, got.torque_b, got.sat_flags);
            end
        endfunction

        function int pending();
            return pending_torques.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    bit          no_idle      = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned cycle_count  = 0;
    int unsigned settings     = 0;

    torque_checker sb = new();

    dapid_cfg_if    cfg_if ();
    dapid_sample_if smp_if ();
    dapid_result_if res_if ();

    dual_axis_pid_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .sample (smp_if),
        .result (res_if)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_if.valid && cfg_if.ready)
            sb.write_reg(cfg_idx_t'(cfg_if.index), cfg_if.data);
        if (rst_n && smp_if.valid && smp_if.ready)
            sb.note_sample('{smp_if.meas_angle_a, smp_if.meas_angle_b, smp_if.target_angle_a,
                             smp_if.target_angle_b, smp_if.elapsed});
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result('{res_if.torque_a, res_if.torque_b, res_if.sat_flags});
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    initial
    begin
        int burst;
        int gap;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                burst = no_idle ? 50 : $urandom_range(1, 16);
                repeat (burst - 1) @(negedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    @(negedge clk);
                    res_if.ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    function automatic sample_word_t make_word(logic signed [31:0] meas_a, meas_b,
                                               targ_a, targ_b, logic [31:0] step);
        return '{meas_a, meas_b, targ_a, targ_b, step};
    endfunction

    function automatic logic signed [31:0] angle_edge();
        case ($urandom_range(0, 4))
            0:       return ANGLE_MIN;
            1:       return ANGLE_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic [31:0] rand_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'h0;
        if (r < 20)
            return $urandom_range(1, 255);
        if (r < 60)
            return $urandom_range(16777, 1677722);
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0001;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0100_0000;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic void make_joint(output logic signed [31:0] targ, meas);
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                targ = $urandom;
                meas = $urandom;
            end
            3, 4, 5:
            begin
                targ = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                meas = targ + ($urandom_range(0, 32'h7FFF) - 32'h4000);
            end
            6:
            begin
                targ = angle_edge();
                meas = angle_edge();
            end
            default:
            begin
                targ = $urandom;
                meas = targ - ($urandom_range(0, 32'h0FFF) - 32'h0800);
            end
        endcase
    endfunction

    function automatic sample_word_t random_word();
        sample_word_t w;
        make_joint(w.target_angle_a, w.meas_angle_a);
        make_joint(w.target_angle_b, w.meas_angle_b);
        w.elapsed = rand_elapsed();
        return w;
    endfunction

    // drive joint one towards positive and joint two towards negative integral limits
    function automatic sample_word_t windup_word();
        sample_word_t w;
        w.target_angle_a = $urandom_range(32'h6000_0000, 32'h7FFF_FFFF);
        w.meas_angle_a   = $urandom_range(32'h8000_0000, 32'hA000_0000);
        w.target_angle_b = $urandom_range(32'h8000_0000, 32'hA000_0000);
        w.meas_angle_b   = $urandom_range(32'h6000_0000, 32'h7FFF_FFFF);
        w.elapsed        = $urandom_range(32'hE000_0000, 32'hFFFF_FFFF);
        return w;
    endfunction

    task automatic drive_sample(sample_word_t w, int gap);
        if (gap > 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_if.meas_angle_a   <= w.meas_angle_a;
        smp_if.meas_angle_b   <= w.meas_angle_b;
        smp_if.target_angle_a <= w.target_angle_a;
        smp_if.target_angle_b <= w.target_angle_b;
        smp_if.elapsed        <= w.elapsed;
        smp_if.valid          <= 1'b1;
        do @(posedge clk); while (!smp_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_results();
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_regs(logic [31:0] pg, logic [15:0] dt, logic [15:0] ir);
        cfg_idx_t    idx [3];
        logic [31:0] val [3];
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        idx = '{REG_PROP_GAIN, REG_DERIV_TIME, REG_INTEG_RATE};
        val = '{pg, {16'($urandom), dt}, {16'($urandom), ir}};
        for (int i = 0; i < 3; i++)
        begin
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            cfg_if.valid <= 1'b1;
            do @(posedge clk); while (!cfg_if.ready);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    task automatic run_directed();
        drive_sample(make_word(0, 0, 0, 0, 32'h0100_0000), pick_gap());
        drive_sample(make_word(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN, 32'h0), pick_gap());
        drive_sample(make_word(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN, 32'h1), pick_gap());
        drive_sample(make_word(ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN, 32'hFFFF_FFFF),
                     pick_gap());
        drive_sample(make_word(0, 0, 0, 0, 32'hFFFF_FFFF), pick_gap());
        drive_sample(make_word(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX, 32'h1), pick_gap());
        drive_sample(make_word(0, 0, 1, -1, 32'h0100_0000), pick_gap());
        drive_sample(make_word(0, 0, 0, 0, 32'h0), pick_gap());
        drive_sample(make_word(ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, 32'd16777),
                     pick_gap());
        drive_sample(make_word(0, 32'sh0001_0000, 32'sh0001_0000, 0, 32'd16777), pick_gap());
        drive_sample(make_word(1, -1, -1, 1, 32'h1), pick_gap());
        drive_sample(make_word(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                               32'h5555_5555), pick_gap());
        drive_sample(make_word(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
                               32'hAAAA_AAAA), pick_gap());
        drive_sample(make_word(0, ANGLE_MIN, ANGLE_MIN, 0, 32'h8000_0000), pick_gap());
        drive_sample(make_word(-1, 0, 0, -1, 32'h0000_00FF), pick_gap());
        drive_sample(make_word(0, 0, 0, 0, 32'h0100_0000), pick_gap());
    endtask

    task automatic run_random(int count, bit windup);
        int           sent;
        sample_word_t w;
        sent = 0;
        while (sent < count)
        begin
            w = windup ? windup_word() : random_word();
            if (w.elapsed != 0)
                sent++;
            drive_sample(w, pick_gap());
        end
        smp_if.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        smp_if.valid          = 1'b0;
        smp_if.meas_angle_a   = '0;
        smp_if.meas_angle_b   = '0;
        smp_if.target_angle_a = '0;
        smp_if.target_angle_b = '0;
        smp_if.elapsed        = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_PROP_GAIN;
        cfg_if.data           = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(100, 1'b0);

        write_regs($urandom_range(1, 32'h0001_0000), 16'hFFFF, 16'hFFFF);
        hold_off_req = 1'b1;
        run_random(100, 1'b0);

        write_regs(32'h0, 16'h0, 16'h0);
        run_random(40, 1'b0);

        write_regs(32'hFFFF_FFFF, 16'($urandom), 16'h0);
        run_random(80, 1'b0);

        write_regs($urandom_range(1, 32'h0000_4000), 16'($urandom), 16'($urandom));
        no_idle = 1'b1;
        run_random(200, 1'b1);
        no_idle = 1'b0;

        write_regs($urandom, 16'($urandom), 16'($urandom));
        run_random(100, 1'b0);

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d sample words (%0d with zero elapsed time), %0d results checked",
                 sb.samples, sb.idle_samples, sb.results);
        $display("%0d results carried saturation flags over %0d gain settings after reset",
                 sb.sat_results, settings);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
